@@ hw/rtl/vtq_pkg.sv @@
// ----------------------------------------------------------------------------
// vtq_pkg: shared types and constants for the vocabulary tree quantiser
// widths of the fixed fields, register codes and control bundles
// ----------------------------------------------------------------------------
`default_nettype none

package vtq_pkg;

  localparam int DEF_MAX_DIM    = 128;
  localparam int DEF_MAX_BRANCH = 8;
  localparam int DEF_MAX_LEVELS = 4;
  localparam int DEF_VALUE_BITS = 16;

  localparam int ADDR_W = 20;
  localparam int LEAF_W = 12;
  localparam int RANK_W = 3;
  localparam int DIST_W = 39;
  localparam int CNT_W  = 8;
  localparam int CFG_W  = 8;
  localparam int CIDX_W = 3;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic [3:0] RST_BRANCHING = 4'd8;
  localparam logic [2:0] RST_LEVELS    = 3'd4;
  localparam logic [7:0] RST_DIM       = 8'd128;
  localparam logic [3:0] RST_MULTI     = 4'd1;

  typedef enum logic [CIDX_W-1:0] {
    CFG_BRANCHING = 3'd0,
    CFG_LEVELS    = 3'd1,
    CFG_DIM       = 3'd2,
    CFG_MULTI     = 3'd3
  } cfg_idx_e;

  typedef struct packed {
    logic issue;
    logic last;
    logic clear;
  } mac_ctl_t;

  typedef struct packed {
    logic insert;
    logic pop;
    logic clear;
  } cell_op_t;

  // nodes of a full tree with the given fan-out and depth
  function automatic int node_count(input int branch, input int lvls);
    int total;
    int p;
    total = 1;
    p     = 1;
    for (int i = 0; i < lvls; i++) begin
      p     = p * branch;
      total = total + p;
    end
    return total;
  endfunction

  function automatic int clog2_min1(input int v);
    int r;
    r = $clog2(v);
    return (r < 1) ? 1 : r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/vtq_in_if.sv @@
// ----------------------------------------------------------------------------
// vtq_in_if: request channel
// codebook writes and query elements with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface vtq_in_if #(
  parameter int VALUE_BITS = vtq_pkg::DEF_VALUE_BITS
);
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [vtq_pkg::ADDR_W-1:0]    word_addr;
  logic signed [VALUE_BITS-1:0]  value;

  modport source (output valid, kind, word_addr, value, input ready);
  modport sink   (input valid, kind, word_addr, value, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/vtq_out_if.sv @@
// ----------------------------------------------------------------------------
// vtq_out_if: result channel
// one word per emitted leaf with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface vtq_out_if;
  logic                        valid;
  logic                        ready;
  logic [vtq_pkg::LEAF_W-1:0]  leaf_index;
  logic [vtq_pkg::RANK_W-1:0]  rank;
  logic [vtq_pkg::DIST_W-1:0]  distance;
  logic                        last;

  modport source (output valid, leaf_index, rank, distance, last, input ready);
  modport sink   (input valid, leaf_index, rank, distance, last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/vtq_mac.sv @@
// ----------------------------------------------------------------------------
// vtq_mac: distance unit
// codebook and query memories feeding one squared-difference accumulator
// ----------------------------------------------------------------------------
`default_nettype none

module vtq_mac #(
  parameter int MAX_DIM    = vtq_pkg::DEF_MAX_DIM,
  parameter int VALUE_BITS = vtq_pkg::DEF_VALUE_BITS,
  parameter int CB_DEPTH   = 599168
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     cb_we_i,
  input  wire logic [vtq_pkg::clog2_min1(CB_DEPTH)-1:0] cb_waddr_i,
  input  wire logic signed [VALUE_BITS-1:0]             cb_wdata_i,
  input  wire logic                                     q_we_i,
  input  wire logic [vtq_pkg::clog2_min1(MAX_DIM)-1:0]  q_waddr_i,
  input  wire logic signed [VALUE_BITS-1:0]             q_wdata_i,
  input  wire vtq_pkg::mac_ctl_t                        ctl_i,
  input  wire logic [vtq_pkg::clog2_min1(CB_DEPTH)-1:0] cb_raddr_i,
  input  wire logic [vtq_pkg::clog2_min1(MAX_DIM)-1:0]  q_raddr_i,
  output logic [vtq_pkg::DIST_W-1:0]                    acc_o,
  output logic                                          done_o
);

  localparam int VB = VALUE_BITS;
  localparam int PW = 2 * VB + 2;
  localparam int SW = ((vtq_pkg::DIST_W > PW) ? vtq_pkg::DIST_W : PW) + 1;

  logic signed [VB-1:0] cb_mem [CB_DEPTH];
  logic signed [VB-1:0] q_mem  [MAX_DIM];

  logic signed [VB-1:0] c_q, qv_q;
  logic                 v1_q, l1_q, v2_q, l2_q, done_q;
  logic [PW-1:0]        prod_q;
  logic [vtq_pkg::DIST_W-1:0] acc_q, acc_d;
  logic signed [VB:0]   diff;
  logic signed [PW-1:0] sq;
  logic [SW-1:0]        sum;

  always_ff @(posedge clk_i) begin
    if (cb_we_i) begin
      cb_mem[cb_waddr_i] <= cb_wdata_i;
    end
    if (ctl_i.issue) begin
      c_q <= cb_mem[cb_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_we_i) begin
      q_mem[q_waddr_i] <= q_wdata_i;
    end
    if (ctl_i.issue) begin
      qv_q <= q_mem[q_raddr_i];
    end
  end

  assign diff = {qv_q[VB-1], qv_q} - {c_q[VB-1], c_q};
  assign sq   = PW'(diff) * PW'(diff);

  always_ff @(posedge clk_i) begin
    prod_q <= sq;
  end

  always_comb begin
    sum = SW'(acc_q) + SW'(prod_q);
    if (ctl_i.clear) begin
      acc_d = '0;
    end else if (!v2_q) begin
      acc_d = acc_q;
    end else if (sum > SW'(vtq_pkg::DIST_MAX)) begin
      acc_d = vtq_pkg::DIST_MAX;
    end else begin
      acc_d = sum[vtq_pkg::DIST_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      l1_q   <= 1'b0;
      v2_q   <= 1'b0;
      l2_q   <= 1'b0;
      done_q <= 1'b0;
      acc_q  <= '0;
    end else begin
      v1_q   <= ctl_i.issue;
      l1_q   <= ctl_i.issue & ctl_i.last;
      v2_q   <= v1_q;
      l2_q   <= l1_q;
      done_q <= v2_q & l2_q;
      acc_q  <= acc_d;
    end
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

@@ hw/rtl/vtq_cell.sv @@
// ----------------------------------------------------------------------------
// vtq_cell: one slot of the sorting chain
// keeps one (distance, child) pair; inserts shift right, pops shift left
// ----------------------------------------------------------------------------
`default_nettype none

module vtq_cell #(
  parameter int IDX_W = 3
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire vtq_pkg::cell_op_t             op_i,
  input  wire logic [vtq_pkg::DIST_W-1:0]    new_dist_i,
  input  wire logic [IDX_W-1:0]              new_idx_i,
  input  wire logic                          prv_valid_i,
  input  wire logic [vtq_pkg::DIST_W-1:0]    prv_dist_i,
  input  wire logic [IDX_W-1:0]              prv_idx_i,
  input  wire logic                          prv_gt_i,
  input  wire logic                          nxt_valid_i,
  input  wire logic [vtq_pkg::DIST_W-1:0]    nxt_dist_i,
  input  wire logic [IDX_W-1:0]              nxt_idx_i,
  output logic                               valid_o,
  output logic [vtq_pkg::DIST_W-1:0]         dist_o,
  output logic [IDX_W-1:0]                   idx_o,
  output logic                               gt_o
);

  logic                       valid_q, valid_d;
  logic [vtq_pkg::DIST_W-1:0] dist_q, dist_d;
  logic [IDX_W-1:0]           idx_q, idx_d;

  // strict compare keeps equal distances in arrival order
  assign gt_o = !valid_q || (dist_q > new_dist_i);

  always_comb begin
    valid_d = valid_q;
    dist_d  = dist_q;
    idx_d   = idx_q;
    priority if (op_i.clear) begin
      valid_d = 1'b0;
    end else if (op_i.insert && gt_o) begin
      if (prv_gt_i) begin
        valid_d = prv_valid_i;
        dist_d  = prv_dist_i;
        idx_d   = prv_idx_i;
      end else begin
        valid_d = 1'b1;
        dist_d  = new_dist_i;
        idx_d   = new_idx_i;
      end
    end else if (op_i.pop) begin
      valid_d = nxt_valid_i;
      dist_d  = nxt_dist_i;
      idx_d   = nxt_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
    idx_q  <= idx_d;
  end

  assign valid_o = valid_q;
  assign dist_o  = dist_q;
  assign idx_o   = idx_q;

endmodule

`default_nettype wire

@@ hw/rtl/vocab_tree_quantizer.sv @@
// ----------------------------------------------------------------------------
// vocab_tree_quantizer: k-ary vocabulary tree descent with multi-assignment
// ----------------------------------------------------------------------------
// req_i carries words: kind 0 writes a codebook word at word_addr (no result),
// kind 1 appends a query element. After dim elements the block descends the
// tree and returns multi_assign words on res_o, nearest first, with last on
// the final one. Configuration is written through cfg_we_i, cfg_idx_i and
// cfg_data_i; the user must write it only while the block is idle, as the
// block itself does not enforce this. One distance unit does one
// multiply-accumulate per cycle while a child's elements are issued; each
// child's dim elements are issued, then read, squared and accumulated before
// the insert into the sorting chain, and each level adds a setup and a
// decision state. Leaves are emitted one per cycle while res_o is not stalled.
// The sorting chain of cells orders children as their distances arrive.
// req_i.ready is high only while no query is being worked on.
// Reset restores the default registers and empties counters and the chain;
// codebook and query memories are not cleared. If res_o is stalled the
// result register holds and emission waits.
// ----------------------------------------------------------------------------
`default_nettype none

module vocab_tree_quantizer #(
  parameter int MAX_DIM    = vtq_pkg::DEF_MAX_DIM,
  parameter int MAX_BRANCH = vtq_pkg::DEF_MAX_BRANCH,
  parameter int MAX_LEVELS = vtq_pkg::DEF_MAX_LEVELS,
  parameter int VALUE_BITS = vtq_pkg::DEF_VALUE_BITS
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [vtq_pkg::CIDX_W-1:0]   cfg_idx_i,
  input  wire logic [vtq_pkg::CFG_W-1:0]    cfg_data_i,
  vtq_in_if.sink                            req_i,
  vtq_out_if.source                         res_o
);

  localparam int NODES    = vtq_pkg::node_count(MAX_BRANCH, MAX_LEVELS);
  localparam int CB_DEPTH = NODES * MAX_DIM;
  localparam int CBA_W    = vtq_pkg::clog2_min1(CB_DEPTH);
  localparam int NODE_W   = vtq_pkg::clog2_min1(NODES);
  localparam int E_W      = vtq_pkg::clog2_min1(MAX_DIM);
  localparam int DV_W     = $clog2(MAX_DIM + 1);
  localparam int J_W      = vtq_pkg::clog2_min1(MAX_BRANCH);
  localparam int K_W      = $clog2(MAX_BRANCH + 1);
  localparam int LEV_W    = vtq_pkg::clog2_min1(MAX_LEVELS);
  localparam int L_W      = $clog2(MAX_LEVELS + 1);
  localparam int LW       = vtq_pkg::LEAF_W;
  localparam int DW       = vtq_pkg::DIST_W;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SETUP  = 6'b000010,
    ST_CALC   = 6'b000100,
    ST_WAIT   = 6'b001000,
    ST_DECIDE = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [3:0] branching_q;
  logic [2:0] levels_q;
  logic [7:0] dim_q;
  logic [3:0] multi_q;
  logic [K_W-1:0]  k_val;
  logic [L_W-1:0]  l_val;
  logic [DV_W-1:0] d_val;
  logic [K_W-1:0]  ma_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      branching_q <= vtq_pkg::RST_BRANCHING;
      levels_q    <= vtq_pkg::RST_LEVELS;
      dim_q       <= vtq_pkg::RST_DIM;
      multi_q     <= vtq_pkg::RST_MULTI;
    end else if (cfg_we_i) begin
      unique case (vtq_pkg::cfg_idx_e'(cfg_idx_i))
        vtq_pkg::CFG_BRANCHING: branching_q <= cfg_data_i[3:0];
        vtq_pkg::CFG_LEVELS:    levels_q    <= cfg_data_i[2:0];
        vtq_pkg::CFG_DIM:       dim_q       <= cfg_data_i;
        vtq_pkg::CFG_MULTI:     multi_q     <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(branching_q) < 2)               k_val = K_W'(2);
    else if (int'(branching_q) > MAX_BRANCH) k_val = K_W'(MAX_BRANCH);
    else                                     k_val = K_W'(branching_q);
    if (int'(levels_q) < 1)                  l_val = L_W'(1);
    else if (int'(levels_q) > MAX_LEVELS)    l_val = L_W'(MAX_LEVELS);
    else                                     l_val = L_W'(levels_q);
    if (int'(dim_q) < 1)                     d_val = DV_W'(1);
    else if (int'(dim_q) > MAX_DIM)          d_val = DV_W'(MAX_DIM);
    else                                     d_val = DV_W'(dim_q);
    if (int'(multi_q) < 1)                   ma_val = K_W'(1);
    else if (int'(multi_q) > int'(k_val))    ma_val = k_val;
    else                                     ma_val = K_W'(multi_q);
  end

  // input side
  logic                 acc_in;
  logic                 cb_we;
  logic                 q_we;
  logic [vtq_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt_inc;
  logic                 start;

  assign req_i.ready = (state_q == ST_IDLE);
  assign acc_in      = req_i.valid && req_i.ready;
  assign cb_we       = acc_in && !req_i.kind && (int'(req_i.word_addr) < CB_DEPTH);
  assign q_we        = acc_in && req_i.kind && (int'(cnt_q) < MAX_DIM);
  assign cnt_inc     = cnt_q + 1'b1;

  always_comb begin
    cnt_d = cnt_q;
    start = 1'b0;
    if (acc_in && req_i.kind) begin
      if (int'(cnt_inc) >= int'(d_val)) begin
        cnt_d = '0;
        start = 1'b1;
      end else begin
        cnt_d = cnt_inc;
      end
    end
  end

  // tree walk
  logic [NODE_W-1:0] g_q, g_d;
  logic [LW-1:0]     path_q, path_d;
  logic [LEV_W-1:0]  lev_q, lev_d;
  logic [J_W-1:0]    j_q, j_d;
  logic [E_W-1:0]    e_q, e_d;
  logic [J_W-1:0]    r_q, r_d;
  logic [CBA_W-1:0]  abase_q, abase_d;

  vtq_pkg::mac_ctl_t mac_ctl;
  vtq_pkg::cell_op_t cell_op;
  logic [DW-1:0]     acc;
  logic              mac_done;

  logic              out_valid_q, out_valid_d, out_load;
  logic [LW-1:0]     out_leaf_q;
  logic [vtq_pkg::RANK_W-1:0] out_rank_q;
  logic [DW-1:0]     out_dist_q;
  logic              out_last_q;

  logic              c_valid [MAX_BRANCH];
  logic [DW-1:0]     c_dist  [MAX_BRANCH];
  logic [J_W-1:0]    c_idx   [MAX_BRANCH];
  logic              c_gt    [MAX_BRANCH];

  logic [LW+K_W-1:0]     leaf_wide;
  logic [NODE_W+K_W:0]   g_next;

  assign leaf_wide = (LW + K_W)'(path_q) * (LW + K_W)'(k_val) + (LW + K_W)'(c_idx[0]);
  assign g_next    = ((NODE_W + K_W + 1)'(g_q) + (NODE_W + K_W + 1)'(c_idx[0]))
                     * (NODE_W + K_W + 1)'(k_val) + 1'b1;

  always_comb begin
    state_d     = state_q;
    g_d         = g_q;
    path_d      = path_q;
    lev_d       = lev_q;
    j_d         = j_q;
    e_d         = e_q;
    r_d         = r_q;
    abase_d     = abase_q;
    mac_ctl     = '0;
    cell_op     = '0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !res_o.ready;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          g_d           = NODE_W'(1);
          path_d        = '0;
          lev_d         = '0;
          cell_op.clear = 1'b1;
          state_d       = ST_SETUP;
        end
      end
      ST_SETUP: begin
        abase_d       = CBA_W'((NODE_W + DV_W)'(g_q) * (NODE_W + DV_W)'(d_val));
        j_d           = '0;
        e_d           = '0;
        mac_ctl.clear = 1'b1;
        state_d       = ST_CALC;
      end
      ST_CALC: begin
        mac_ctl.issue = 1'b1;
        if (int'(e_q) == int'(d_val) - 1) begin
          mac_ctl.last = 1'b1;
          state_d      = ST_WAIT;
        end else begin
          e_d = e_q + 1'b1;
        end
      end
      ST_WAIT: begin
        if (mac_done) begin
          cell_op.insert = 1'b1;
          mac_ctl.clear  = 1'b1;
          if (int'(j_q) == int'(k_val) - 1) begin
            state_d = ST_DECIDE;
          end else begin
            j_d     = j_q + 1'b1;
            e_d     = '0;
            abase_d = abase_q + CBA_W'(d_val);
            state_d = ST_CALC;
          end
        end
      end
      ST_DECIDE: begin
        if (int'(lev_q) == int'(l_val) - 1) begin
          r_d     = '0;
          state_d = ST_EMIT;
        end else begin
          g_d           = NODE_W'(g_next);
          path_d        = leaf_wide[LW-1:0];
          lev_d         = lev_q + 1'b1;
          cell_op.clear = 1'b1;
          state_d       = ST_SETUP;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || res_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          cell_op.pop = 1'b1;
          if (int'(r_q) == int'(ma_val) - 1) begin
            state_d = ST_IDLE;
          end else begin
            r_d = r_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      g_q         <= '0;
      path_q      <= '0;
      lev_q       <= '0;
      j_q         <= '0;
      e_q         <= '0;
      r_q         <= '0;
      abase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      g_q         <= g_d;
      path_q      <= path_d;
      lev_q       <= lev_d;
      j_q         <= j_d;
      e_q         <= e_d;
      r_q         <= r_d;
      abase_q     <= abase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_leaf_q <= leaf_wide[LW-1:0];
      out_rank_q <= vtq_pkg::RANK_W'(r_q);
      out_dist_q <= c_dist[0];
      out_last_q <= (int'(r_q) == int'(ma_val) - 1);
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.leaf_index = out_leaf_q;
  assign res_o.rank       = out_rank_q;
  assign res_o.distance   = out_dist_q;
  assign res_o.last       = out_last_q;

  vtq_mac #(
    .MAX_DIM    (MAX_DIM),
    .VALUE_BITS (VALUE_BITS),
    .CB_DEPTH   (CB_DEPTH)
  ) u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cb_we_i    (cb_we),
    .cb_waddr_i (CBA_W'(req_i.word_addr)),
    .cb_wdata_i (req_i.value),
    .q_we_i     (q_we),
    .q_waddr_i  (E_W'(cnt_q)),
    .q_wdata_i  (req_i.value),
    .ctl_i      (mac_ctl),
    .cb_raddr_i (abase_q + CBA_W'(e_q)),
    .q_raddr_i  (e_q),
    .acc_o      (acc),
    .done_o     (mac_done)
  );

  // sorting chain, nearest at cell 0
  for (genvar i = 0; i < MAX_BRANCH; i++) begin : g_cell
    logic           pv, pg, nv;
    logic [DW-1:0]  pd, nd;
    logic [J_W-1:0] pi, ni;

    if (i == 0) begin : g_head
      assign pv = 1'b0;
      assign pg = 1'b0;
      assign pd = '0;
      assign pi = '0;
    end else begin : g_body
      assign pv = c_valid[i-1];
      assign pg = c_gt[i-1];
      assign pd = c_dist[i-1];
      assign pi = c_idx[i-1];
    end

    if (i == MAX_BRANCH - 1) begin : g_tail
      assign nv = 1'b0;
      assign nd = '0;
      assign ni = '0;
    end else begin : g_mid
      assign nv = c_valid[i+1];
      assign nd = c_dist[i+1];
      assign ni = c_idx[i+1];
    end

    vtq_cell #(
      .IDX_W (J_W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (cell_op),
      .new_dist_i  (acc),
      .new_idx_i   (j_q),
      .prv_valid_i (pv),
      .prv_dist_i  (pd),
      .prv_idx_i   (pi),
      .prv_gt_i    (pg),
      .nxt_valid_i (nv),
      .nxt_dist_i  (nd),
      .nxt_idx_i   (ni),
      .valid_o     (c_valid[i]),
      .dist_o      (c_dist[i]),
      .idx_o       (c_idx[i]),
      .gt_o        (c_gt[i])
    );
  end

endmodule

`default_nettype wire

@@ tb/vtq_leaf_checker.sv @@
// ----------------------------------------------------------------------------
// vtq_leaf_checker: result checker for the vocabulary tree quantiser
// mirrors codebook, query buffer and registers from the observed channels,
// predicts the ranked leaves of each completed query and compares every word
// ----------------------------------------------------------------------------
module vtq_leaf_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [vtq_pkg::CIDX_W-1:0]  cfg_idx_i,
  input  logic [vtq_pkg::CFG_W-1:0]   cfg_data_i,
  vtq_in_if                           req,
  vtq_out_if                          res,
  output int                          mismatches_o,
  output int                          leaves_due_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import vtq_pkg::*;

  typedef struct packed {
    logic [LEAF_W-1:0] leaf_index;
    logic [RANK_W-1:0] rank;
    logic [DIST_W-1:0] distance;
    logic              last;
  } leaf_word_t;

  localparam int CB_WORDS = node_count(DEF_MAX_BRANCH, DEF_MAX_LEVELS) * DEF_MAX_DIM;

  logic [3:0]             branching_q;
  logic [2:0]             levels_q;
  logic [7:0]             dim_q;
  logic [3:0]             multi_q;
  shortint                centroid_mem [int];
  shortint                query_vec [DEF_MAX_DIM];
  logic [7:0]             elem_cnt;
  leaf_word_t             leaves_due [$];

  function automatic int clamp(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [DIST_W-1:0] sq_dist(input int node, input int d);
    longint acc;
    longint diff;
    int     addr;
    acc = 0;
    for (int e = 0; e < d; e++) begin
      addr = node * d + e;
      diff = longint'(query_vec[e]);
      if (addr < CB_WORDS && centroid_mem.exists(addr))
        diff = diff - longint'(centroid_mem[addr]);
      acc += diff * diff;
    end
    if (acc > longint'(DIST_MAX)) acc = longint'(DIST_MAX);
    return acc[DIST_W-1:0];
  endfunction

  // descend the upper levels, then rank the children of the final node
  function automatic void rank_leaves();
    int                k, l, d, ma, g, path, best, sel;
    logic [DIST_W-1:0] bestd, dj;
    logic [DIST_W-1:0] child_d [DEF_MAX_BRANCH];
    bit                taken [DEF_MAX_BRANCH];
    leaf_word_t        w;
    k    = clamp(branching_q, 2, DEF_MAX_BRANCH);
    l    = clamp(levels_q, 1, DEF_MAX_LEVELS);
    d    = clamp(dim_q, 1, DEF_MAX_DIM);
    ma   = clamp(multi_q, 1, k);
    g    = 0;
    path = 0;
    for (int lev = 0; lev + 1 < l; lev++) begin
      g     = g * k + 1;
      best  = 0;
      bestd = '0;
      for (int j = 0; j < k; j++) begin
        dj = sq_dist(g + j, d);
        if (j == 0 || dj < bestd) begin
          bestd = dj;
          best  = j;
        end
      end
      g    = g + best;
      path = path * k + best;
    end
    g = g * k + 1;
    for (int j = 0; j < k; j++) begin
      child_d[j] = sq_dist(g + j, d);
      taken[j]   = 1'b0;
    end
    for (int r = 0; r < ma; r++) begin
      sel = -1;
      for (int j = 0; j < k; j++) begin
        if (!taken[j] && (sel < 0 || child_d[j] < child_d[sel])) sel = j;
      end
      taken[sel]   = 1'b1;
      w.leaf_index = LEAF_W'(path * k + sel);
      w.rank       = RANK_W'(r);
      w.distance   = child_d[sel];
      w.last       = (r + 1 == ma);
      leaves_due.push_back(w);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    leaf_word_t exp_w;
    if (!rst_ni) begin
      branching_q  = RST_BRANCHING;
      levels_q     = RST_LEVELS;
      dim_q        = RST_DIM;
      multi_q      = RST_MULTI;
      elem_cnt     = '0;
      mismatches_o = 0;
      leaves_due.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_BRANCHING: branching_q = cfg_data_i[3:0];
          CFG_LEVELS:    levels_q    = cfg_data_i[2:0];
          CFG_DIM:       dim_q       = cfg_data_i;
          CFG_MULTI:     multi_q     = cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        if (!req.kind) begin
          if (int'(req.word_addr) < CB_WORDS) centroid_mem[int'(req.word_addr)] = req.value;
        end else begin
          if (elem_cnt < DEF_MAX_DIM) query_vec[elem_cnt] = req.value;
          elem_cnt = elem_cnt + 8'd1;
          if (int'(elem_cnt) >= clamp(dim_q, 1, DEF_MAX_DIM)) begin
            elem_cnt = '0;
            rank_leaves();
          end
        end
      end
      if (res.valid && res.ready) begin
        if (leaves_due.size() == 0) begin
          $display("%0t: unexpected word leaf %0d rank %0d dist %0d", $realtime,
                   res.leaf_index, res.rank, res.distance);
          mismatches_o++;
        end else begin
          exp_w = leaves_due.pop_front();
          if (res.leaf_index !== exp_w.leaf_index) begin
            $display("%0t: leaf_index exp %0d got %0d", $realtime, exp_w.leaf_index,
                     res.leaf_index);
            mismatches_o++;
          end
          if (res.rank !== exp_w.rank) begin
            $display("%0t: rank exp %0d got %0d", $realtime, exp_w.rank, res.rank);
            mismatches_o++;
          end
          if (res.distance !== exp_w.distance) begin
            $display("%0t: distance exp %0d got %0d", $realtime, exp_w.distance,
                     res.distance);
            mismatches_o++;
          end
          if (res.last !== exp_w.last) begin
            $display("%0t: last exp %0d got %0d", $realtime, exp_w.last, res.last);
            mismatches_o++;
          end
        end
      end
    end
    leaves_due_o = leaves_due.size();
  end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the vocabulary tree quantiser
// loads full trees at several register settings, runs directed and random
// queries with stalls on both channels, and reports the checker's verdict
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import vtq_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [CIDX_W-1:0]   cfg_idx;
  logic [CFG_W-1:0]    cfg_data;
  int                  mismatches;
  int                  leaves_due;
  bit                  calm;
  bit                  long_hold;
  int                  k_use, l_use, d_use, tree_nodes;

  vtq_in_if  req_if ();
  vtq_out_if res_if ();

  vocab_tree_quantizer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  vtq_leaf_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .req          (req_if),
    .res          (res_if),
    .mismatches_o (mismatches),
    .leaves_due_o (leaves_due)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        res_if.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  function automatic logic [15:0] pick_value(input int spread);
    if (spread == 0) return 16'($urandom);
    return 16'($urandom_range(0, 2 * spread) - spread);
  endfunction

  task automatic send_word(input logic kind, input logic [ADDR_W-1:0] addr,
                           input logic [15:0] val);
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.kind      <= kind;
    req_if.word_addr <= addr;
    req_if.value     <= val;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // lower valid and wait for every leaf word, then let the block settle
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (leaves_due != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input int data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CFG_W'(data);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic setup(input int kr, input int lr, input int dr, input int mr);
    cfg_write(CFG_BRANCHING, kr);
    cfg_write(CFG_LEVELS, lr);
    cfg_write(CFG_DIM, dr);
    cfg_write(CFG_MULTI, mr);
    k_use      = (kr < 2) ? 2 : ((kr > 8) ? 8 : kr);
    l_use      = (lr < 1) ? 1 : ((lr > 4) ? 4 : lr);
    d_use      = (dr < 1) ? 1 : ((dr > 128) ? 128 : dr);
    tree_nodes = node_count(k_use, l_use);
  endtask

  task automatic load_tree(input int spread);
    for (int a = 0; a < tree_nodes * d_use; a++) send_word(1'b0, ADDR_W'(a), pick_value(spread));
  endtask

  // one query vector, with stray codebook words mixed in
  task automatic query(input int spread);
    for (int e = 0; e < d_use; e++) begin
      if ($urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 1) == 0)
          send_word(1'b0, ADDR_W'($urandom_range(599168, 1048575)), pick_value(0));
        else
          send_word(1'b0, ADDR_W'($urandom_range(0, tree_nodes * d_use - 1)),
                    pick_value(spread));
      end
      send_word(1'b1, ADDR_W'($urandom), pick_value(spread));
    end
  endtask

  task automatic run_phase(input int kr, input int lr, input int dr, input int mr,
                           input int queries, input int spread, input bit hold);
    drain();
    setup(kr, lr, dr, mr);
    load_tree(spread);
    if (hold) long_hold = 1'b1;
    repeat (queries) begin
      query(spread);
      if ($urandom_range(0, 9) == 0) drain();
    end
  endtask

  initial begin
    rst_ni           <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= '0;
    cfg_data         <= '0;
    req_if.valid     <= 1'b0;
    req_if.kind      <= 1'b0;
    req_if.word_addr <= '0;
    req_if.value     <= '0;
    calm      = 1'b0;
    long_hold = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // saturating registers: branching 2, one level, three elements, two leaves
    setup(0, 0, 3, 15);
    for (int a = 0; a < 9; a++) send_word(1'b0, ADDR_W'(a), 16'h0000);
    send_word(1'b0, 20'hFFFFF, 16'h7FFF);
    // all children tie, lower index first
    for (int e = 0; e < 3; e++) send_word(1'b1, '0, 16'h0000);
    send_word(1'b1, 20'hFFFFF, 16'h7FFF);
    send_word(1'b1, 20'h00000, 16'h8000);
    send_word(1'b1, 20'hAAAAA, 16'h7FFF);
    drain();
    load_tree(0);
    for (int e = 0; e < 3; e++) send_word(1'b1, 20'h55555, 16'h8000);
    for (int e = 0; e < 3; e++) send_word(1'b1, 20'hFFFFF, 16'h7FFF);
    // dim changed part way through a query, codebook word in the middle
    drain();
    cfg_write(CFG_DIM, 4);
    send_word(1'b1, '0, pick_value(0));
    send_word(1'b0, ADDR_W'(4), pick_value(0));
    send_word(1'b1, '0, pick_value(0));
    drain();
    cfg_write(CFG_DIM, 3);
    send_word(1'b1, '0, pick_value(0));

    run_phase(8, 2, 1, 8, 40, 3, 1'b1);
    run_phase(15, 1, 2, 1, 20, 0, 1'b0);
    run_phase(0, 7, 2, 0, 20, 2, 1'b0);
    drain();
    calm = 1'b1;
    run_phase(5, 2, 3, 3, 10, 4, 1'b0);
    drain();
    repeat (50) @(posedge clk_i);

    if (mismatches == 0 && leaves_due == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ vocab_tree_quantizer.f @@
hw/rtl/vtq_pkg.sv
hw/rtl/vtq_in_if.sv
hw/rtl/vtq_out_if.sv
hw/rtl/vtq_mac.sv
hw/rtl/vtq_cell.sv
hw/rtl/vocab_tree_quantizer.sv
tb/vtq_leaf_checker.sv
tb/testbench.sv
